FILE: rtl/core/priority_alarm_tone_selector_assert.svh
// assertion macros for the priority alarm tone selector
`ifndef PRIORITY_ALARM_TONE_SELECTOR_ASSERT_SVH
`define PRIORITY_ALARM_TONE_SELECTOR_ASSERT_SVH

// same-cycle implication, clocked on clk, off during rst
`define PATS_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("pats assertion failed");

// next-cycle implication, clocked on clk, off during rst
`define PATS_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("pats assertion failed");

`endif

FILE: rtl/core/pats_pkg.sv
// shared types and constants of the priority alarm tone selector
package pats_pkg;

  localparam int LEVELS_DEF     = 8;
  localparam int NOTE_COUNT_DEF = 7;
  localparam int NOTE_REGS      = 7;

  localparam int PERIOD_W = 16;
  localparam int DUTY_W   = 11;
  localparam int TONE_W   = 3;
  localparam int LEVEL_W  = 4;
  localparam int NOTE_IW  = 4;
  localparam int LOUD_W   = 12;
  localparam int CFG_IW   = 3;
  localparam int SLOT_W   = TONE_W + DUTY_W;

  localparam logic [DUTY_W-1:0] FULL_DUTY = DUTY_W'(1024);

  localparam logic [PERIOD_W-1:0] PERIOD_RESET [NOTE_REGS] = '{
    16'd3822, 16'd3405, 16'd3034, 16'd2863, 16'd2551, 16'd2273, 16'd2025
  };

  typedef enum logic [1:0] {
    OP_REGISTER = 2'd0,
    OP_STATUS   = 2'd1,
    OP_TICK     = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_RANGE    = 3'd1,
    ST_DUP      = 3'd2,
    ST_BAD_NOTE = 3'd3,
    ST_IGNORED  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DRAIN
  } state_t;

  typedef struct packed {
    logic                 done;
    status_t              status;
    logic                 sounding;
    logic [PERIOD_W-1:0]  tone_period;
    logic [DUTY_W-1:0]    duty;
  } result_t;

  function automatic logic [DUTY_W-1:0] clamp_loud(input logic [LOUD_W-1:0] raw);
    logic [DUTY_W-1:0] v;
    if (raw[LOUD_W-1]) begin
      v = '0;
    end else if (raw[LOUD_W-2]) begin
      v = FULL_DUTY;
    end else begin
      v = {1'b0, raw[LOUD_W-3:0]};
    end
    return v;
  endfunction

endpackage

FILE: rtl/core/pats_ram.sv
// generic single-port-write ram with registered read
module pats_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/pats_note_regs.sv
// note period registers with config write port and period lookup
module pats_note_regs
  import pats_pkg::*;
#(
  parameter int NOTE_COUNT = NOTE_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_IW-1:0]   cfg_index,
  input  logic [PERIOD_W-1:0] cfg_data,
  input  logic [TONE_W-1:0]   note_sel,
  output logic [PERIOD_W-1:0] period
);

  logic [PERIOD_W-1:0] regs [NOTE_REGS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NOTE_REGS; i++) begin
        regs[i] <= PERIOD_RESET[i];
      end
    end else if (cfg_valid && cfg_ready && (int'(cfg_index) < NOTE_REGS)) begin
      regs[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    if ((int'(note_sel) < NOTE_COUNT) && (int'(note_sel) < NOTE_REGS)) begin
      period = regs[note_sel];
    end else begin
      period = '0;
    end
  end

endmodule

FILE: rtl/core/pats_ctrl.sv
// sequencer for slot flags, slot ram writes, tick scan and result register
module pats_ctrl
  import pats_pkg::*;
#(
  parameter int LEVELS     = LEVELS_DEF,
  parameter int NOTE_COUNT = NOTE_COUNT_DEF,
  localparam int IW = (LEVELS > 1) ? $clog2(LEVELS) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          operation,
  input  logic [LEVEL_W-1:0]  level,
  input  logic [NOTE_IW-1:0]  tone,
  input  logic [LOUD_W-1:0]   loudness_in,
  input  logic                turn_on,
  output logic                ram_we,
  output logic [IW-1:0]       ram_waddr,
  output logic [SLOT_W-1:0]   ram_wdata,
  output logic [IW-1:0]       ram_raddr,
  input  logic [SLOT_W-1:0]   ram_rdata,
  output logic [TONE_W-1:0]   note_sel,
  input  logic [PERIOD_W-1:0] period,
  output result_t             res
);

  state_t state, state_next;
  op_t                 op_q;
  logic [LEVEL_W-1:0]  lvl_q;
  logic [NOTE_IW-1:0]  tone_q;
  logic [DUTY_W-1:0]   loud_q;
  logic                on_q;
  logic [IW-1:0]       scan_idx;
  logic                chk_vld;
  logic                chk_q;
  logic [LEVELS-1:0]   slot_valid;
  logic [LEVELS-1:0]   slot_on;
  logic [PERIOD_W-1:0] last_period;

  logic [IW-1:0] sel_idx;
  logic          fl_valid, fl_on;
  logic          lvl_ok, tone_ok, hit, finish, on_we;
  status_t       status_c;

  assign busy      = (state != S_IDLE);
  assign sel_idx   = (state == S_SCAN) ? scan_idx : lvl_q[IW-1:0];
  assign fl_valid  = slot_valid[sel_idx];
  assign fl_on     = slot_on[sel_idx];
  assign lvl_ok    = int'(lvl_q) < LEVELS;
  assign tone_ok   = int'(tone_q) < NOTE_COUNT;
  assign ram_raddr = scan_idx;
  assign ram_waddr = lvl_q[IW-1:0];
  assign ram_wdata = {tone_q[TONE_W-1:0], loud_q};
  assign note_sel  = ram_rdata[SLOT_W-1 -: TONE_W];
  assign hit       = ((state == S_SCAN) || (state == S_DRAIN)) && chk_vld && chk_q
                     && (period != '0);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = (op_t'(operation) == OP_TICK) ? S_SCAN : S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
      end
      S_SCAN: begin
        if (hit) begin
          state_next = S_IDLE;
        end else if (int'(scan_idx) == LEVELS - 1) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    status_c = ST_OK;
    ram_we   = 1'b0;
    on_we    = 1'b0;
    finish   = hit || (state == S_EXEC) || (state == S_DRAIN);
    if (state == S_EXEC) begin
      unique case (op_q)
        OP_REGISTER: begin
          if (!lvl_ok) begin
            status_c = ST_RANGE;
          end else if (fl_valid) begin
            status_c = ST_DUP;
          end else if (!tone_ok) begin
            status_c = ST_BAD_NOTE;
          end else begin
            ram_we = 1'b1;
          end
        end
        OP_STATUS: begin
          if (!lvl_ok || !fl_valid) begin
            status_c = ST_IGNORED;
          end else begin
            on_we = 1'b1;
          end
        end
        OP_TICK: begin
          status_c = ST_OK;
        end
        default: begin
          status_c = ST_IGNORED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      scan_idx    <= '0;
      chk_vld     <= 1'b0;
      slot_valid  <= '0;
      slot_on     <= '0;
      last_period <= '0;
      res.done    <= 1'b0;
    end else begin
      state    <= state_next;
      chk_vld  <= (state == S_SCAN);
      res.done <= finish;
      if (state == S_SCAN) begin
        scan_idx <= scan_idx + IW'(1);
      end else begin
        scan_idx <= '0;
      end
      if (ram_we) begin
        slot_valid[lvl_q[IW-1:0]] <= 1'b1;
        slot_on[lvl_q[IW-1:0]]    <= 1'b0;
      end
      if (on_we) begin
        slot_on[lvl_q[IW-1:0]] <= on_q;
      end
      if (hit) begin
        last_period <= period;
      end
      if (finish) begin
        res.status      <= status_c;
        res.sounding    <= hit;
        res.duty        <= hit ? ram_rdata[DUTY_W-1:0] : '0;
        res.tone_period <= hit ? period : last_period;
      end
    end
  end

  // captured item and scan flag pipe
  always_ff @(posedge clk) begin
    chk_q <= fl_valid && fl_on;
    if (start && !busy) begin
      op_q   <= op_t'(operation);
      lvl_q  <= level;
      tone_q <= tone;
      loud_q <= clamp_loud(loudness_in);
      on_q   <= turn_on;
    end
  end

endmodule

FILE: rtl/core/priority_alarm_tone_selector.sv
// top level of the priority alarm tone selector
//
// Command channel: an item (operation, level, tone, loudness_in, turn_on)
// transfers at a rising edge with start high and busy low. busy stays high
// until the result appears; one item is worked on at a time.
// Result channel: done pulses for one cycle with status, sounding,
// tone_period and duty; the receiver cannot stall it and must take it then.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data writes the
// note period registers (index 0..6); cfg_ready is always high, indexes past
// the list are dropped. Write config only while the block is idle.
// Register and set-status operations pass through the exec state before done
// is registered. A tick scans the slot ram one level per cycle through its
// single read port, checking each level after its registered read; the lowest
// armed level with a nonzero period is a hit, else the scan ends past the last.
// Reset (rst, synchronous) clears all slots, the on bits and the remembered
// period, and reloads the note period registers; no clearing pass is needed.
module priority_alarm_tone_selector
  import pats_pkg::*;
#(
  parameter int LEVELS     = LEVELS_DEF,
  parameter int NOTE_COUNT = NOTE_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          operation,
  input  logic [LEVEL_W-1:0]  level,
  input  logic [NOTE_IW-1:0]  tone,
  input  logic [LOUD_W-1:0]   loudness_in,
  input  logic                turn_on,
  output logic                done,
  output logic [2:0]          status,
  output logic                sounding,
  output logic [PERIOD_W-1:0] tone_period,
  output logic [DUTY_W-1:0]   duty,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_IW-1:0]   cfg_index,
  input  logic [PERIOD_W-1:0] cfg_data
);

  `include "priority_alarm_tone_selector_assert.svh"

  localparam int IW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  logic                ram_we;
  logic [IW-1:0]       ram_waddr, ram_raddr;
  logic [SLOT_W-1:0]   ram_wdata, ram_rdata;
  logic [TONE_W-1:0]   note_sel;
  logic [PERIOD_W-1:0] period;
  result_t             res;

  pats_note_regs #(
    .NOTE_COUNT(NOTE_COUNT)
  ) u_notes (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .note_sel (note_sel),
    .period   (period)
  );

  pats_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(LEVELS)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  pats_ctrl #(
    .LEVELS    (LEVELS),
    .NOTE_COUNT(NOTE_COUNT)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .operation  (operation),
    .level      (level),
    .tone       (tone),
    .loudness_in(loudness_in),
    .turn_on    (turn_on),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .note_sel   (note_sel),
    .period     (period),
    .res        (res)
  );

  assign done        = res.done;
  assign status      = res.status;
  assign sounding    = res.sounding;
  assign tone_period = res.tone_period;
  assign duty        = res.duty;

  `PATS_ASSERT_NXT(a_start_busy, start && !busy, busy)
  `PATS_ASSERT_NXT(a_busy_ends, busy, busy || done)
  `PATS_ASSERT_IMP(a_done_idle, done, !busy)
  `PATS_ASSERT_IMP(a_duty_sound, done && (duty != '0), sounding)
  `PATS_ASSERT_IMP(a_sound_period, done && sounding, tone_period != '0)

endmodule

FILE: bench/alarm_tone_checker.sv
// checker for the priority alarm tone selector: predicts each command's result and compares
`timescale 1ns / 100ps

module alarm_tone_checker
  import pats_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  logic [1:0]          operation,
  input  logic [LEVEL_W-1:0]  level,
  input  logic [NOTE_IW-1:0]  tone,
  input  logic [LOUD_W-1:0]   loudness_in,
  input  logic                turn_on,
  input  logic                done,
  input  logic [2:0]          status,
  input  logic                sounding,
  input  logic [PERIOD_W-1:0] tone_period,
  input  logic [DUTY_W-1:0]   duty,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [CFG_IW-1:0]   cfg_index,
  input  logic [PERIOD_W-1:0] cfg_data,
  output int                  mismatch_count,
  output int                  results_due
);

  typedef struct packed {
    status_t             status;
    logic                sounding;
    logic [PERIOD_W-1:0] period;
    logic [DUTY_W-1:0]   duty;
  } tone_result_t;

  localparam int MAX_REPORTS = 40;

  logic [PERIOD_W-1:0] note_ticks [NOTE_REGS];
  logic                slot_used [LEVELS_DEF];
  logic [TONE_W-1:0]   slot_note [LEVELS_DEF];
  logic [DUTY_W-1:0]   slot_duty [LEVELS_DEF];
  logic                slot_armed [LEVELS_DEF];
  logic [PERIOD_W-1:0] held_period;
  tone_result_t        results_owed [$];

  initial begin
    mismatch_count = 0;
    results_due = 0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_REPORTS) begin
      $display("%0t mismatch: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  function automatic logic [DUTY_W-1:0] limit_loudness(input logic [LOUD_W-1:0] raw);
    if (raw[LOUD_W-1]) begin
      return '0;
    end
    if (raw >= {1'b0, FULL_DUTY}) begin
      return FULL_DUTY;
    end
    return raw[DUTY_W-1:0];
  endfunction

  // applies one command to the alarm table and returns what it should show
  function automatic tone_result_t play_command(input logic [1:0] op,
                                                input logic [LEVEL_W-1:0] lvl,
                                                input logic [NOTE_IW-1:0] tn,
                                                input logic [LOUD_W-1:0] loud,
                                                input logic on);
    tone_result_t r;
    logic [PERIOD_W-1:0] p;
    logic hit;
    r.status = ST_OK;
    r.sounding = 1'b0;
    r.duty = '0;
    hit = 1'b0;
    case (op)
      OP_REGISTER: begin
        if (lvl >= LEVELS_DEF) begin
          r.status = ST_RANGE;
        end else if (slot_used[lvl]) begin
          r.status = ST_DUP;
        end else if (tn >= NOTE_COUNT_DEF) begin
          r.status = ST_BAD_NOTE;
        end else begin
          slot_used[lvl] = 1'b1;
          slot_note[lvl] = tn[TONE_W-1:0];
          slot_duty[lvl] = limit_loudness(loud);
          slot_armed[lvl] = 1'b0;
        end
      end
      OP_STATUS: begin
        if (lvl >= LEVELS_DEF || !slot_used[lvl]) begin
          r.status = ST_IGNORED;
        end else begin
          slot_armed[lvl] = on;
        end
      end
      OP_TICK: begin
        for (int k = 0; k < LEVELS_DEF; k++) begin
          if (!hit && slot_used[k] && slot_armed[k]) begin
            p = (slot_note[k] < NOTE_COUNT_DEF) ? note_ticks[slot_note[k]] : '0;
            if (p != '0) begin
              hit = 1'b1;
              held_period = p;
              r.sounding = 1'b1;
              r.duty = slot_duty[k];
            end
          end
        end
      end
      default: begin
        r.status = ST_IGNORED;
      end
    endcase
    r.period = held_period;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    tone_result_t want;
    if (rst) begin
      for (int i = 0; i < NOTE_REGS; i++) begin
        note_ticks[i] = PERIOD_RESET[i];
      end
      for (int i = 0; i < LEVELS_DEF; i++) begin
        slot_used[i] = 1'b0;
        slot_note[i] = '0;
        slot_duty[i] = '0;
        slot_armed[i] = 1'b0;
      end
      held_period = '0;
      results_owed.delete();
    end else begin
      if (done) begin
        if (results_owed.size() == 0) begin
          report_mismatch($sformatf("result with no command outstanding, status %0d", status));
        end else begin
          want = results_owed.pop_front();
          if (status !== want.status) begin
            report_mismatch($sformatf("status %0d, want %0d", status, want.status));
          end
          if (sounding !== want.sounding) begin
            report_mismatch($sformatf("sounding %b, want %b", sounding, want.sounding));
          end
          if (tone_period !== want.period) begin
            report_mismatch($sformatf("tone_period %0d, want %0d", tone_period, want.period));
          end
          if (duty !== want.duty) begin
            report_mismatch($sformatf("duty %0d, want %0d", duty, want.duty));
          end
        end
      end
      if (cfg_valid && cfg_ready && cfg_index < NOTE_REGS) begin
        note_ticks[cfg_index] = cfg_data;
      end
      if (start && !busy) begin
        results_owed.push_back(play_command(operation, level, tone, loudness_in, turn_on));
      end
    end
    results_due = results_owed.size();
  end

endmodule

FILE: bench/tb_priority_alarm_tone_selector.sv
// testbench top for the priority alarm tone selector: stimulus, watchdog and verdict
`timescale 1ns / 100ps

module tb_priority_alarm_tone_selector;
  import pats_pkg::*;

  typedef enum logic [CFG_IW-1:0] {
    REG_DO, REG_RE, REG_MI, REG_FA, REG_SO, REG_LA, REG_SI, REG_SPARE
  } note_reg_t;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int STALL_LIMIT      = 200;
  localparam int SETTLE_CYCLES    = LEVELS_DEF + 4;
  localparam int PHASES           = 5;
  localparam int PHASE_ITEMS      = 245;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [1:0]          operation;
  logic [LEVEL_W-1:0]  level;
  logic [NOTE_IW-1:0]  tone;
  logic [LOUD_W-1:0]   loudness_in;
  logic                turn_on;
  logic                done;
  logic [2:0]          status;
  logic                sounding;
  logic [PERIOD_W-1:0] tone_period;
  logic [DUTY_W-1:0]   duty;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CFG_IW-1:0]   cfg_index;
  logic [PERIOD_W-1:0] cfg_data;
  int                  mismatch_count;
  int                  results_due;

  priority_alarm_tone_selector DUT (.*);

  alarm_tone_checker checker_i (.*);

  initial begin
    clk = 1'b0;
  end

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic send_command(input logic [1:0] op, input logic [LEVEL_W-1:0] lvl,
                              input logic [NOTE_IW-1:0] tn, input logic [LOUD_W-1:0] loud,
                              input logic on);
    @(negedge clk);
    start <= 1'b1;
    operation <= op;
    level <= lvl;
    tone <= tn;
    loudness_in <= loud;
    turn_on <= on;
    do begin
      @(posedge clk);
    end while (busy);
  endtask

  task automatic write_period(input note_reg_t idx, input logic [PERIOD_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
  endtask

  task automatic close_config;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_quiet;
    @(negedge clk);
    start <= 1'b0;
    while (results_due != 0 || busy) begin
      @(negedge clk);
    end
  endtask

  task automatic send_random(input bit with_gaps);
    int pick;
    int gap;
    logic [1:0] op;
    logic [LEVEL_W-1:0] lvl;
    logic [NOTE_IW-1:0] tn;
    if (with_gaps && $urandom_range(0, 99) < 30) begin
      gap = $urandom_range(1, 16);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      op = OP_REGISTER;
    end else if (pick < 50) begin
      op = OP_STATUS;
    end else if (pick < 95) begin
      op = OP_TICK;
    end else begin
      op = OP_SPARE;
    end
    lvl = ($urandom_range(0, 99) < 85) ? LEVEL_W'($urandom_range(0, LEVELS_DEF - 1))
                                       : LEVEL_W'($urandom_range(LEVELS_DEF, 15));
    tn = ($urandom_range(0, 99) < 70) ? NOTE_IW'($urandom_range(0, NOTE_COUNT_DEF - 1))
                                      : NOTE_IW'($urandom_range(NOTE_COUNT_DEF, 15));
    send_command(op, lvl, tn, LOUD_W'($urandom), 1'($urandom));
  endtask

  // period settings per phase: all max, all zero, sparse zeros, full random, reset values
  function automatic logic [PERIOD_W-1:0] phase_period(input int ph, input int idx);
    case (ph)
      0: return '1;
      1: return '0;
      2: return ($urandom_range(0, 99) < 30) ? '0 : PERIOD_W'($urandom);
      3: return PERIOD_W'($urandom);
      default: return (idx < NOTE_REGS) ? PERIOD_RESET[idx] : PERIOD_W'($urandom);
    endcase
  endfunction

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    rst = 1'b1;
    start = 1'b0;
    operation = OP_REGISTER;
    level = '0;
    tone = '0;
    loudness_in = '0;
    turn_on = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_DO;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // note do silenced, re and mi at the extremes, the rest keep reset values
    write_period(REG_DO, '0);
    write_period(REG_RE, '1);
    write_period(REG_MI, 16'd1);
    write_period(REG_SPARE, 16'd777);
    close_config();

    send_command(OP_TICK, 4'd0, 4'd0, 12'd0, 1'b0);
    send_command(OP_STATUS, 4'd3, 4'd0, 12'd0, 1'b1);
    send_command(OP_STATUS, 4'd12, 4'd0, 12'd0, 1'b1);
    send_command(OP_REGISTER, 4'd15, 4'd0, 12'd5, 1'b0);
    send_command(OP_REGISTER, 4'd8, 4'd0, 12'd5, 1'b0);
    send_command(OP_REGISTER, 4'd0, 4'd7, 12'd5, 1'b0);
    send_command(OP_REGISTER, 4'd0, 4'd15, 12'd5, 1'b0);
    send_command(OP_REGISTER, 4'd0, 4'd0, 12'h800, 1'b1);
    send_command(OP_REGISTER, 4'd0, 4'd1, 12'd100, 1'b0);
    send_command(OP_REGISTER, 4'd1, 4'd1, 12'h7ff, 1'b0);
    send_command(OP_REGISTER, 4'd2, 4'd2, 12'd1024, 1'b0);
    send_command(OP_REGISTER, 4'd3, 4'd6, 12'd1023, 1'b0);
    send_command(OP_REGISTER, 4'd4, 4'd3, 12'hfff, 1'b0);
    send_command(OP_REGISTER, 4'd5, 4'd4, 12'd1, 1'b0);
    send_command(OP_TICK, 4'd0, 4'd0, 12'd0, 1'b0);
    send_command(OP_STATUS, 4'd0, 4'd0, 12'd0, 1'b1);
    send_command(OP_TICK, 4'd0, 4'd0, 12'd0, 1'b0);
    send_command(OP_STATUS, 4'd3, 4'd0, 12'd0, 1'b1);
    send_command(OP_TICK, 4'd0, 4'd0, 12'd0, 1'b0);
    send_command(OP_STATUS, 4'd1, 4'd0, 12'd0, 1'b1);
    send_command(OP_TICK, 4'd0, 4'd0, 12'd0, 1'b0);
    send_command(OP_STATUS, 4'd1, 4'd0, 12'd0, 1'b0);
    send_command(OP_TICK, 4'd0, 4'd0, 12'd0, 1'b0);
    send_command(OP_STATUS, 4'd3, 4'd0, 12'd0, 1'b0);
    send_command(OP_TICK, 4'd0, 4'd0, 12'd0, 1'b0);
    send_command(OP_SPARE, 4'd2, 4'd2, 12'd2, 1'b1);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_quiet();
      for (int i = 0; i <= REG_SPARE; i++) begin
        write_period(note_reg_t'(i), phase_period(ph, i));
      end
      close_config();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_random(ph != PHASES - 1);
      end
    end

    wait_quiet();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
